>>> sv/nlcc_pkg.sv
// ============================================================================
// nlcc_pkg - NMEA line checksum checker package
// Shared constants, the check phase type and the character helper functions.
// ============================================================================
package nlcc_pkg;

    // Characters kept per line, and the last position that may hold the star.
    localparam int LINE_CAPACITY = 255;
    localparam int CHECK_SPAN    = 75;
    localparam int PREFIX_LEN    = 6;

    // Width of the character counter, which must be able to hold the capacity.
    localparam int COUNT_W = $clog2(LINE_CAPACITY + 1);

    // Special characters.
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    // Sentence kind codes.
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_RMC   = 2'd2;

    // Progress of the checksum check within one line.
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Uppercase hex character of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] r;
        if (nibble < 4'd10) begin
            r = 8'h30 + {4'd0, nibble};
        end else begin
            r = 8'h37 + {4'd0, nibble};
        end
        return r;
    endfunction

    // Expected character of the "$GPGGA" prefix at a position.
    function automatic logic [7:0] gga_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h24; // '$'
            3'd1:    r = 8'h47; // 'G'
            3'd2:    r = 8'h50; // 'P'
            3'd3:    r = 8'h47; // 'G'
            3'd4:    r = 8'h47; // 'G'
            3'd5:    r = 8'h41; // 'A'
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Expected character of the "$GPRMC" prefix at a position.
    function automatic logic [7:0] rmc_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h24; // '$'
            3'd1:    r = 8'h47; // 'G'
            3'd2:    r = 8'h50; // 'P'
            3'd3:    r = 8'h52; // 'R'
            3'd4:    r = 8'h4D; // 'M'
            3'd5:    r = 8'h43; // 'C'
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> sv/nmea_line_checksum_checker.sv
// ============================================================================
// nmea_line_checksum_checker - NMEA 0183 line checksum checker
// Checks the XOR checksum of each received line and reports its sentence kind.
// ============================================================================
//
//  Channel  | Direction | Payload (tdata, lowest bit first)
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | [7:0] rx_byte
//  m_axis   | out       | [0] line_valid, [2:1] sentence_kind, [7:3] zero
//
//  One byte is accepted in every cycle while ready is high. The line state
//  registers are updated directly from the accepted byte. A newline loads its
//  result into the output register, or into the skid register while one waits.
//  A skid register behind the output register keeps input accepted while one
//  result waits; ready falls only when both are full.
//  Reset (synchronous, active low) clears the line state and both result slots.
//
module nmea_line_checksum_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [0] line_valid, [2:1] sentence_kind
);

    localparam int CW = nlcc_pkg::COUNT_W;

    // Line state.
    logic [CW-1:0]        r_char_count, n_char_count;
    logic [7:0]           r_xor_sum, n_xor_sum;
    nlcc_pkg::t_phase     r_phase, n_phase;
    logic [7:0]           r_first_digit, n_first_digit;
    logic [7:0]           r_second_digit, n_second_digit;
    logic                 r_text_ended, n_text_ended;
    logic [1:0]           r_prefix_flags, n_prefix_flags;

    // Result slots.
    logic       r_out_valid, r_skid_valid;
    logic [2:0] r_out_data, r_skid_data;

    logic       s_accept;
    logic       s_is_lf;
    logic       s_is_cr;
    logic       s_out_free;
    logic       s_line_valid;
    logic [1:0] s_kind;
    logic [7:0] c;

    assign c          = i_s_axis_tdata;
    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign s_is_lf    = (c == nlcc_pkg::CHAR_LF);
    assign s_is_cr    = (c == nlcc_pkg::CHAR_CR);
    assign s_out_free = !r_out_valid || i_m_axis_tready;

    // Result of the current line, evaluated from the state before the newline.
    always_comb begin
        s_line_valid = (r_phase == nlcc_pkg::PH_DONE)
                    && (r_first_digit  == nlcc_pkg::hex_char(r_xor_sum[7:4]))
                    && (r_second_digit == nlcc_pkg::hex_char(r_xor_sum[3:0]));
        s_kind = nlcc_pkg::KIND_OTHER;
        if (s_line_valid && (r_char_count >= CW'(nlcc_pkg::PREFIX_LEN))) begin
            if (r_prefix_flags[0]) begin
                s_kind = nlcc_pkg::KIND_GGA;
            end else if (r_prefix_flags[1]) begin
                s_kind = nlcc_pkg::KIND_RMC;
            end
        end
    end

    // Handshake and output drive.
    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_data};

    // Next line state for each accepted byte.
    always_comb begin
        n_char_count   = r_char_count;
        n_xor_sum      = r_xor_sum;
        n_phase        = r_phase;
        n_first_digit  = r_first_digit;
        n_second_digit = r_second_digit;
        n_text_ended   = r_text_ended;
        n_prefix_flags = r_prefix_flags;
        if (s_accept && !s_is_cr) begin
            if (s_is_lf) begin
                // Clear for the next line.
                n_char_count   = '0;
                n_xor_sum      = 8'd0;
                n_phase        = nlcc_pkg::PH_SEARCH;
                n_first_digit  = 8'd0;
                n_second_digit = 8'd0;
                n_text_ended   = 1'b0;
                n_prefix_flags = 2'b11;
            end else if (r_char_count < CW'(nlcc_pkg::LINE_CAPACITY)) begin
                n_char_count = r_char_count + CW'(1);
                if (!r_text_ended) begin
                    if (c == nlcc_pkg::CHAR_NUL) begin
                        // A zero byte ends the checked text.
                        n_text_ended = 1'b1;
                        if (r_char_count < CW'(nlcc_pkg::PREFIX_LEN)) begin
                            n_prefix_flags = 2'b00;
                        end
                    end else begin
                        if (r_char_count < CW'(nlcc_pkg::PREFIX_LEN)) begin
                            if (c != nlcc_pkg::gga_char(r_char_count[2:0])) begin
                                n_prefix_flags[0] = 1'b0;
                            end
                            if (c != nlcc_pkg::rmc_char(r_char_count[2:0])) begin
                                n_prefix_flags[1] = 1'b0;
                            end
                        end
                        // The leading character takes no part in the checksum.
                        if (r_char_count != '0) begin
                            case (r_phase)
                                nlcc_pkg::PH_SEARCH: begin
                                    if (c == nlcc_pkg::CHAR_STAR) begin
                                        n_phase = nlcc_pkg::PH_FIRST;
                                    end else if (32'(r_char_count) <
                                                 32'(nlcc_pkg::CHECK_SPAN)) begin
                                        n_xor_sum = r_xor_sum ^ c;
                                    end else begin
                                        // No star within the span: check fails.
                                        n_first_digit  = 8'd0;
                                        n_second_digit = 8'd0;
                                        n_phase        = nlcc_pkg::PH_DONE;
                                    end
                                end
                                nlcc_pkg::PH_FIRST: begin
                                    n_first_digit = c;
                                    n_phase       = nlcc_pkg::PH_SECOND;
                                end
                                nlcc_pkg::PH_SECOND: begin
                                    n_second_digit = c;
                                    n_phase        = nlcc_pkg::PH_DONE;
                                end
                                default: begin
                                    n_phase = r_phase;
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count   <= '0;
            r_xor_sum      <= 8'd0;
            r_phase        <= nlcc_pkg::PH_SEARCH;
            r_first_digit  <= 8'd0;
            r_second_digit <= 8'd0;
            r_text_ended   <= 1'b0;
            r_prefix_flags <= 2'b11;
        end else begin
            r_char_count   <= n_char_count;
            r_xor_sum      <= n_xor_sum;
            r_phase        <= n_phase;
            r_first_digit  <= n_first_digit;
            r_second_digit <= n_second_digit;
            r_text_ended   <= n_text_ended;
            r_prefix_flags <= n_prefix_flags;
        end
    end

    // Output register with skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (s_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= s_accept && s_is_lf;
            end
        end else if (s_accept && s_is_lf) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result payloads.
    always_ff @(posedge i_clk) begin
        if (s_out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (s_accept && s_is_lf) begin
                r_out_data <= {s_kind, s_line_valid};
            end
        end else if (s_accept && s_is_lf) begin
            r_skid_data <= {s_kind, s_line_valid};
        end
    end

    // Assertions.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_clear_after_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_is_lf) |=> (r_char_count == '0 && r_prefix_flags == 2'b11))
        else $error("line state not cleared after a newline");

    a_kind_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:1] == nlcc_pkg::KIND_OTHER
                             || o_m_axis_tdata[0]))
        else $error("sentence kind reported for a line with a bad checksum");

    a_result_for_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_is_lf) |=> o_m_axis_tvalid)
        else $error("newline accepted but no result presented");

endmodule

>>> bench/tb_nmea_line_checksum_checker.sv
// ============================================================================
// tb_nmea_line_checksum_checker - testbench for the NMEA line checksum checker
// Streams NMEA-style lines into the checker, predicts each line verdict with
// an independent model of the checksum and prefix rules, and compares every
// result transaction with the oldest prediction. Both sides idle at random.
// ============================================================================
module tb_nmea_line_checksum_checker;

    // Run control.
    localparam int CYCLE_LIMIT = 150000;
    localparam int RANDOM_BYTES = 580;
    localparam int MIN_LINES = 30;
    localparam int CALM_TAIL = 250;
    localparam int HOLD_AT = 500;
    localparam int HOLD_LEN = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CW = nlcc_pkg::COUNT_W;

    // Sentence prefixes and hex digits, as text.
    localparam logic [47:0] GGA_TEXT = "$GPGGA";
    localparam logic [47:0] RMC_TEXT = "$GPRMC";
    localparam logic [127:0] HEX_TEXT = "0123456789ABCDEF";

    // Ways in which a generated sentence departs from a well-formed one.
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_LOWER_HEX,
        FLAW_NO_DIGITS,
        FLAW_ONE_DIGIT,
        FLAW_NUL_TEXT,
        FLAW_NUL_TAIL,
        FLAW_NO_STAR
    } t_flaw;

    // Verdict carried by one result transaction.
    typedef struct packed {
        logic       line_ok;
        logic [1:0] kind;
    } t_line_verdict;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [0] line_valid, [2:1] sentence_kind

    // Bytes still to be sent, and verdicts still to arrive.
    logic [7:0]    tx_bytes[$];
    logic [7:0]    line_buf[$];
    t_line_verdict verdict_queue[$];

    int  accepted_bytes = 0;
    int  total_bytes = 0;
    int  lines_made = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  in_taken = 1'b0;

    // Copy of the checker's line state.
    logic [CW-1:0]     ln_count;
    logic [7:0]        ln_xor;
    nlcc_pkg::t_phase  ln_phase;
    logic [7:0]        ln_dig1;
    logic [7:0]        ln_dig2;
    logic              ln_ended;
    logic [1:0]        ln_prefix;

    nmea_line_checksum_checker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ASCII hex digit of a nibble, uppercase.
    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n);
        return HEX_TEXT[8 * (15 - int'(n)) +: 8];
    endfunction

    // Idling is allowed outside the quiet stretches and the closing part.
    function automatic bit idle_allowed();
        return (accepted_bytes + CALM_TAIL < total_bytes) && ((accepted_bytes / 300) % 3 != 2);
    endfunction

    function automatic string pick_head(input int k);
        case (k)
            0:       return "$GPGGA";
            1:       return "$GPRMC";
            2:       return "$GPGSV";
            3:       return "$GNRMC";
            4:       return "$GPGGB";
            5:       return "GPGGA,";
            6:       return "$GPRM";
            default: return "$GPRMA";
        endcase
    endfunction

    // Character for the body of a sentence: mostly printable, never a star.
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        if ($urandom_range(0, 19) == 0) begin
            c = 8'($urandom_range(8'h80, 8'hFF));
        end else begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == nlcc_pkg::CHAR_STAR) begin
                c = ",";
            end
        end
        return c;
    endfunction

    // Reset the copy of the line state.
    task automatic clear_line_state();
        ln_count  = '0;
        ln_xor    = 8'h00;
        ln_phase  = nlcc_pkg::PH_SEARCH;
        ln_dig1   = 8'h00;
        ln_dig2   = 8'h00;
        ln_ended  = 1'b0;
        ln_prefix = 2'b11;
    endtask

    // Update the line state with one accepted byte; a newline yields a verdict.
    task automatic predict_line_byte(input logic [7:0] c);
        t_line_verdict v;
        int            pos;
        pos = int'(ln_count);
        if (c == nlcc_pkg::CHAR_CR) begin
            return;
        end
        if (c != nlcc_pkg::CHAR_LF) begin
            if (pos < nlcc_pkg::LINE_CAPACITY) begin
                ln_count = ln_count + CW'(1);
                if (ln_ended) begin
                    return;
                end
                if (c == nlcc_pkg::CHAR_NUL) begin
                    // A zero byte ends the checked text of the line.
                    ln_ended = 1'b1;
                    if (pos < nlcc_pkg::PREFIX_LEN) begin
                        ln_prefix = 2'b00;
                    end
                    return;
                end
                if (pos < nlcc_pkg::PREFIX_LEN) begin
                    if (c != GGA_TEXT[8 * (5 - pos) +: 8]) ln_prefix[0] = 1'b0;
                    if (c != RMC_TEXT[8 * (5 - pos) +: 8]) ln_prefix[1] = 1'b0;
                end
                if (pos == 0) begin
                    return;
                end
                case (ln_phase)
                    nlcc_pkg::PH_SEARCH: begin
                        if (c == nlcc_pkg::CHAR_STAR) begin
                            ln_phase = nlcc_pkg::PH_FIRST;
                        end else if (pos < nlcc_pkg::CHECK_SPAN) begin
                            ln_xor = ln_xor ^ c;
                        end else begin
                            // The star did not appear within the span.
                            ln_dig1  = 8'h00;
                            ln_dig2  = 8'h00;
                            ln_phase = nlcc_pkg::PH_DONE;
                        end
                    end
                    nlcc_pkg::PH_FIRST: begin
                        ln_dig1  = c;
                        ln_phase = nlcc_pkg::PH_SECOND;
                    end
                    nlcc_pkg::PH_SECOND: begin
                        ln_dig2  = c;
                        ln_phase = nlcc_pkg::PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
            return;
        end
        v.line_ok = (ln_phase == nlcc_pkg::PH_DONE)
                    && (ln_dig1 == nibble_to_ascii(ln_xor[7:4]))
                    && (ln_dig2 == nibble_to_ascii(ln_xor[3:0]));
        v.kind = nlcc_pkg::KIND_OTHER;
        if (v.line_ok && int'(ln_count) >= nlcc_pkg::PREFIX_LEN) begin
            if (ln_prefix[0]) begin
                v.kind = nlcc_pkg::KIND_GGA;
            end else if (ln_prefix[1]) begin
                v.kind = nlcc_pkg::KIND_RMC;
            end
        end
        verdict_queue.push_back(v);
        clear_line_state();
    endtask

    // Move the line buffer to the send queue with stray carriage returns.
    task automatic send_line();
        foreach (line_buf[i]) begin
            if ($urandom_range(0, 39) == 0) begin
                tx_bytes.push_back(nlcc_pkg::CHAR_CR);
            end
            tx_bytes.push_back(line_buf[i]);
        end
        if ($urandom_range(0, 1) == 1) begin
            tx_bytes.push_back(nlcc_pkg::CHAR_CR);
        end
        tx_bytes.push_back(nlcc_pkg::CHAR_LF);
        lines_made++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            tx_bytes.push_back(8'(s[i]));
        end
        lines_made++;
    endtask

    // Build one sentence: head, body, star, checksum digits and a tail.
    task automatic put_sentence(input string head, input int body_len, input t_flaw flaw,
                                input int tail_len);
        logic [7:0] sum;
        logic [7:0] d1;
        logic [7:0] d2;
        line_buf.delete();
        for (int i = 0; i < head.len(); i++) begin
            line_buf.push_back(8'(head[i]));
        end
        for (int i = 0; i < body_len; i++) begin
            line_buf.push_back(body_char());
        end
        if (flaw == FLAW_NUL_TEXT && line_buf.size() > 1) begin
            line_buf[$urandom_range(1, line_buf.size() - 1)] = nlcc_pkg::CHAR_NUL;
        end
        sum = 8'h00;
        for (int i = 1; i < line_buf.size(); i++) begin
            sum = sum ^ line_buf[i];
        end
        d1 = nibble_to_ascii(sum[7:4]);
        d2 = nibble_to_ascii(sum[3:0]);
        if (flaw == FLAW_BAD_SUM) begin
            if ($urandom_range(0, 1) == 1) begin
                d1 = d1 ^ (8'h01 << $urandom_range(0, 7));
            end else begin
                d2 = d2 ^ (8'h01 << $urandom_range(0, 7));
            end
        end else if (flaw == FLAW_LOWER_HEX) begin
            if (d1 >= "A") d1 = d1 | 8'h20;
            if (d2 >= "A") d2 = d2 | 8'h20;
        end
        if (flaw != FLAW_NO_STAR) begin
            line_buf.push_back(nlcc_pkg::CHAR_STAR);
            if (flaw != FLAW_NO_DIGITS) begin
                line_buf.push_back(d1);
                if (flaw != FLAW_ONE_DIGIT) begin
                    line_buf.push_back(d2);
                end
            end
        end
        for (int i = 0; i < tail_len; i++) begin
            line_buf.push_back((flaw == FLAW_NUL_TAIL && i == 0) ? nlcc_pkg::CHAR_NUL
                                                                 : body_char());
        end
        send_line();
    endtask

    // Input driver: offers the next byte, or idles between transactions.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 5);
                    i_s_axis_tvalid <= 1'b0;
                end else if (tx_bytes.size() != 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= tx_bytes.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off to fill the block.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && accepted_bytes >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                i_m_axis_tready <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 5);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each input transaction, checks each result transaction.
    always @(posedge i_clk) begin
        t_line_verdict want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_line_byte(i_s_axis_tdata);
                accepted_bytes++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_queue.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got tdata %h",
                             $time, o_m_axis_tdata);
                    error_count++;
                end else begin
                    want = verdict_queue.pop_front();
                    if (o_m_axis_tdata[0] !== want.line_ok) begin
                        $display("%0t: line_valid: expected %0d, got %0d",
                                 $time, want.line_ok, o_m_axis_tdata[0]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[2:1] !== want.kind) begin
                        $display("%0t: sentence_kind: expected %0d, got %0d",
                                 $time, want.kind, o_m_axis_tdata[2:1]);
                        error_count++;
                    end
                end
            end
        end
        in_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
    end

    // Watchdog on the length of the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nmea_line_checksum_checker: mismatch");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int start_bytes;
        int r;
        clear_line_state();

        // Directed lines: prefixes, checksum faults, span and capacity edges.
        put_sentence("$GPGGA", 30, FLAW_NONE, 0);
        put_sentence("$GPRMC", 40, FLAW_NONE, 0);
        put_sentence("$GPGSV", 12, FLAW_NONE, 0);
        put_sentence("$GPGGA", 20, FLAW_BAD_SUM, 0);
        put_sentence("$GPRMC", 25, FLAW_LOWER_HEX, 0);
        put_sentence("$GPGGA", 8, FLAW_NO_DIGITS, 0);
        put_sentence("$GPRMC", 8, FLAW_ONE_DIGIT, 0);
        put_text("\n");
        put_text("\r\n");
        put_text("$*00\n");
        put_text("**00\r\n");
        put_text("$G*47\n");
        put_sentence("$GPGGA", 15, FLAW_NUL_TEXT, 0);
        put_sentence("$GPRMC", 10, FLAW_NUL_TAIL, 6);
        put_sentence("$GPGGA", 69, FLAW_NONE, 0);
        put_sentence("$GPRMC", 70, FLAW_NONE, 0);
        put_sentence("$GPGGA", 90, FLAW_NO_STAR, 0);
        put_sentence("$GPGGA", 20, FLAW_NONE, 300);
        put_sentence("$GPRMC", 260, FLAW_NONE, 0);
        put_sentence("$GPRMC", 5, FLAW_NONE, 0);
        put_text("\xff\x80\x7f\x01*\n");

        // Random lines: mostly well formed, some broken, some pure noise.
        start_bytes = tx_bytes.size();
        while (tx_bytes.size() < start_bytes + RANDOM_BYTES || lines_made < MIN_LINES) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                put_sentence(pick_head($urandom_range(0, 7)), $urandom_range(0, 45), FLAW_NONE,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
            end else if (r < 80) begin
                put_sentence(pick_head($urandom_range(0, 7)), $urandom_range(0, 40),
                             t_flaw'($urandom_range(1, 7)), $urandom_range(0, 2));
            end else if (r < 90) begin
                for (int i = $urandom_range(1, 30); i > 0; i--) begin
                    tx_bytes.push_back(8'($urandom_range(0, 255)));
                end
                tx_bytes.push_back(nlcc_pkg::CHAR_LF);
                lines_made++;
            end else begin
                // Star close to the end of the checked span.
                put_sentence(pick_head($urandom_range(0, 1)), $urandom_range(66, 72),
                             FLAW_NONE, 0);
            end
        end
        total_bytes = tx_bytes.size();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (verdict_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && verdict_queue.size() == 0) begin
            $display("nmea_line_checksum_checker: match");
        end else begin
            $display("nmea_line_checksum_checker: mismatch");
        end
        $finish;
    end

endmodule
